// File: rtl/deadline_min_heap_scheduler_top_defines.svh
// assertion macros for the deadline heap scheduler
`ifndef DEADLINE_MIN_HEAP_SCHEDULER_TOP_DEFINES_SVH
`define DEADLINE_MIN_HEAP_SCHEDULER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DMHS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DMHS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMHS_ASSERT(label, clk, rst, prop, msg)
`define DMHS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/dmhs_pkg.sv
// types and constants for the deadline heap scheduler
package dmhs_pkg;
   localparam int unsigned HEAP_CAPACITY_DEFAULT = 16;
   localparam int unsigned TID_W = 8;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned OP_W = 3;
   localparam int unsigned OCC_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_CHANGE = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DN_SW,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_PEEK_RD,
      ST_ROOT_RD,
      ST_LAST_LD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [TID_W-1:0]         tid;
      logic signed [TIME_W-1:0] deadline;
      logic signed [TIME_W-1:0] remaining;
   } entry_type;

   // strict heap order: lower remaining time, then lower id
   function automatic logic precedes(entry_type a, entry_type b);
      if (a.remaining != b.remaining) return a.remaining < b.remaining;
      return a.tid < b.tid;
   endfunction
endpackage

// File: rtl/deadline_min_heap_scheduler_top.sv
// Deadline heap scheduler: a bounded binary min-heap of tasks ordered by remaining time,
// then task id. One request at a time: busy is high from the accepting edge until the
// rsp_valid cycle. Entries sit in one memory with one read and one write per cycle, and
// every ordering test uses the precedes function. Insert reads and compares the parent at
// each level climbed; remove fetches root and last entry, then reads, compares and swaps
// at each level descended; change deadline scans up to N slots, then rebuilds if the id is
// found; peek and tick rebuild the whole heap (N/2 sift-downs), tick after a decrement
// sweep over all entries. Results appear for one cycle on rsp_valid and cannot be
// stalled. No clearing pass after reset.
`include "deadline_min_heap_scheduler_top_defines.svh"
module deadline_min_heap_scheduler_top #(
   parameter int unsigned HEAP_CAPACITY = dmhs_pkg::HEAP_CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [dmhs_pkg::OP_W-1:0]          req_op,
   input  logic [dmhs_pkg::TID_W-1:0]         req_entry_tid,
   input  logic signed [dmhs_pkg::TIME_W-1:0] req_entry_deadline,
   input  logic signed [dmhs_pkg::TIME_W-1:0] req_entry_remaining,
   output logic                               rsp_valid,
   output logic                               rsp_ok,
   output logic [dmhs_pkg::TID_W-1:0]         rsp_out_tid,
   output logic signed [dmhs_pkg::TIME_W-1:0] rsp_out_deadline,
   output logic signed [dmhs_pkg::TIME_W-1:0] rsp_out_remaining,
   output logic [dmhs_pkg::OCC_W-1:0]         rsp_occupancy
);
   localparam int unsigned AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
   localparam int unsigned CW = $clog2(HEAP_CAPACITY + 1);
   localparam int unsigned IW = AW + 2;

   dmhs_pkg::entry_type mem [HEAP_CAPACITY];

   dmhs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       idx_ff, idx_in;       // current node / scan index
   logic [IW-1:0]       best_ff, best_in;
   logic [IW-1:0]       build_ff, build_in;   // root of the rebuild sift-down in progress
   logic [1:0]          phase_ff, phase_in;   // sift-down read phase: self, left, right
   logic                rebuild_ff, rebuild_in;
   dmhs_pkg::entry_type cur_ff, cur_in;       // entry sinking from idx
   dmhs_pkg::entry_type bst_ff, bst_in;       // best entry so far
   dmhs_pkg::entry_type rd_ff;
   logic [dmhs_pkg::OP_W-1:0] op_ff, op_in;
   dmhs_pkg::entry_type req_ff, req_in;
   logic                ok_ff, ok_in;
   dmhs_pkg::entry_type res_ff, res_in;
   logic                valid_ff, valid_in;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   dmhs_pkg::entry_type wr_data;
   logic                at_done;

   logic [IW-1:0] parent, child_l, child_r, cnt_w;
   assign cnt_w   = IW'(count_ff);
   assign parent  = (idx_ff - IW'(1)) >> 1;
   assign child_l = {idx_ff[IW-2:0], 1'b1};
   assign child_r = child_l + IW'(1);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmhs_pkg::ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      idx_ff     <= idx_in;
      best_ff    <= best_in;
      build_ff   <= build_in;
      phase_ff   <= phase_in;
      rebuild_ff <= rebuild_in;
      cur_ff     <= cur_in;
      bst_ff     <= bst_in;
      op_ff      <= op_in;
      req_ff     <= req_in;
      ok_ff      <= ok_in;
      res_ff     <= res_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dmhs_pkg::ST_IDLE: begin
            if (start) begin
               case (req_op)
                  dmhs_pkg::OP_INSERT:
                     state_in = (cnt_w < IW'(HEAP_CAPACITY)) ? dmhs_pkg::ST_UP_RD
                                                              : dmhs_pkg::ST_DONE;
                  dmhs_pkg::OP_REMOVE:
                     state_in = (count_ff != '0) ? dmhs_pkg::ST_ROOT_RD : dmhs_pkg::ST_DONE;
                  dmhs_pkg::OP_PEEK:
                     state_in = (count_ff != '0) ? dmhs_pkg::ST_PEEK_RD : dmhs_pkg::ST_DONE;
                  dmhs_pkg::OP_CHANGE:
                     state_in = (count_ff != '0) ? dmhs_pkg::ST_SCAN_RD : dmhs_pkg::ST_DONE;
                  dmhs_pkg::OP_TICK:
                     state_in = (count_ff != '0) ? dmhs_pkg::ST_TICK_RD : dmhs_pkg::ST_DONE;
                  default: state_in = dmhs_pkg::ST_DONE;
               endcase
            end
         end
         dmhs_pkg::ST_UP_RD:  state_in = (idx_ff == '0) ? dmhs_pkg::ST_DONE : dmhs_pkg::ST_UP_CMP;
         dmhs_pkg::ST_UP_CMP: state_in = dmhs_pkg::precedes(req_ff, rd_ff) ? dmhs_pkg::ST_UP_RD
                                                                            : dmhs_pkg::ST_DONE;
         dmhs_pkg::ST_ROOT_RD: state_in = dmhs_pkg::ST_LAST_LD;
         dmhs_pkg::ST_LAST_LD: state_in = dmhs_pkg::ST_DN_RD;
         dmhs_pkg::ST_PEEK_RD: state_in = rebuild_ff ? dmhs_pkg::ST_DONE : dmhs_pkg::ST_DN_RD;
         dmhs_pkg::ST_DN_RD:  state_in = dmhs_pkg::ST_DN_CMP;
         dmhs_pkg::ST_DN_CMP: begin
            if (phase_ff == 2'd2 || (phase_ff == 2'd1 && child_r >= cnt_w) ||
                (phase_ff == 2'd0 && child_l >= cnt_w))
               state_in = dmhs_pkg::ST_DN_SW;
            else
               state_in = dmhs_pkg::ST_DN_RD;
         end
         dmhs_pkg::ST_DN_SW: begin
            if (best_ff != idx_ff) state_in = dmhs_pkg::ST_DN_RD;
            else if (rebuild_ff && build_ff != '0) state_in = dmhs_pkg::ST_DN_RD;
            else if (op_ff == dmhs_pkg::OP_PEEK) state_in = dmhs_pkg::ST_PEEK_RD;
            else state_in = dmhs_pkg::ST_DONE;
         end
         dmhs_pkg::ST_SCAN_RD:  state_in = dmhs_pkg::ST_SCAN_CHK;
         dmhs_pkg::ST_SCAN_CHK: begin
            if (rd_ff.tid == req_ff.tid) state_in = dmhs_pkg::ST_DN_RD;
            else if (idx_ff + IW'(1) >= cnt_w) state_in = dmhs_pkg::ST_DONE;
            else state_in = dmhs_pkg::ST_SCAN_RD;
         end
         dmhs_pkg::ST_TICK_RD: state_in = dmhs_pkg::ST_TICK_WR;
         dmhs_pkg::ST_TICK_WR:
            state_in = (idx_ff + IW'(1) >= cnt_w) ? dmhs_pkg::ST_DN_RD : dmhs_pkg::ST_TICK_RD;
         dmhs_pkg::ST_DONE: state_in = dmhs_pkg::ST_IDLE;
         default: state_in = dmhs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      best_in    = best_ff;
      build_in   = build_ff;
      phase_in   = phase_ff;
      rebuild_in = rebuild_ff;
      cur_in     = cur_ff;
      bst_in     = bst_ff;
      op_in      = op_ff;
      req_in     = req_ff;
      ok_in      = ok_ff;
      res_in     = res_ff;
      valid_in   = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = req_ff;
      unique case (state_ff)
         dmhs_pkg::ST_IDLE: begin
            if (start) begin
               op_in  = req_op;
               req_in = '{tid: req_entry_tid, deadline: req_entry_deadline,
                          remaining: req_entry_remaining};
               ok_in  = 1'b0;
               res_in = '0;
               idx_in = '0;
               phase_in = 2'd0;
               rebuild_in = 1'b0;
               if (req_op == dmhs_pkg::OP_INSERT) begin
                  idx_in = cnt_w;
                  if (cnt_w < IW'(HEAP_CAPACITY)) begin
                     count_in = count_ff + CW'(1);
                     ok_in = 1'b1;
                  end
               end
               if (req_op == dmhs_pkg::OP_TICK) ok_in = 1'b1;
               if (req_op == dmhs_pkg::OP_PEEK || req_op == dmhs_pkg::OP_REMOVE) begin
                  rd_en = 1'b1;
                  rd_addr = '0;
               end
            end
         end
         dmhs_pkg::ST_UP_RD: begin
            if (idx_ff == '0) begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff);
            end else begin
               rd_en = 1'b1;
               rd_addr = AW'(parent);
            end
         end
         dmhs_pkg::ST_UP_CMP: begin
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff);
            if (dmhs_pkg::precedes(req_ff, rd_ff)) begin
               wr_data = rd_ff;
               idx_in = parent;
            end
         end
         dmhs_pkg::ST_PEEK_RD: begin
            idx_in = '0;
            phase_in = 2'd0;
            if (rebuild_ff) begin
               // second pass: root now final
               res_in = rd_ff;
               ok_in = 1'b1;
               rebuild_in = 1'b0;
               build_in = '0;
            end else begin
               // idle task on top loses its place while others wait
               if (rd_ff.tid == '0 && count_ff > CW'(1)) begin
                  wr_en = 1'b1;
                  wr_addr = '0;
                  wr_data = '{tid: rd_ff.tid, deadline: rd_ff.deadline,
                              remaining: rd_ff.deadline};
               end
               rebuild_in = 1'b1;
               build_in = cnt_w >> 1;
               if ((cnt_w >> 1) != '0) begin
                  idx_in = (cnt_w >> 1) - IW'(1);
                  build_in = (cnt_w >> 1) - IW'(1);
               end else begin
                  rebuild_in = 1'b0;
               end
            end
         end
         dmhs_pkg::ST_ROOT_RD: begin
            // last entry moves to the root and sinks
            res_in = rd_ff;
            ok_in = 1'b1;
            count_in = count_ff - CW'(1);
            idx_in = '0;
            phase_in = 2'd0;
            rd_en = 1'b1;
            rd_addr = AW'(cnt_w - IW'(1));
         end
         dmhs_pkg::ST_LAST_LD: begin
            cur_in = rd_ff;
            bst_in = rd_ff;
            best_in = '0;
            idx_in = '0;
            phase_in = 2'd1;
         end
         dmhs_pkg::ST_DN_RD: begin
            rd_en = 1'b1;
            unique case (phase_ff)
               2'd0: rd_addr = AW'(idx_ff);
               2'd1: rd_addr = AW'(child_l);
               default: rd_addr = AW'(child_r);
            endcase
         end
         dmhs_pkg::ST_DN_CMP: begin
            unique case (phase_ff)
               2'd0: begin
                  cur_in = rd_ff;
                  bst_in = rd_ff;
                  best_in = idx_ff;
               end
               2'd1: begin
                  if (child_l < cnt_w && dmhs_pkg::precedes(rd_ff, bst_ff)) begin
                     bst_in = rd_ff;
                     best_in = child_l;
                  end
               end
               default: begin
                  if (child_r < cnt_w && dmhs_pkg::precedes(rd_ff, bst_ff)) begin
                     bst_in = rd_ff;
                     best_in = child_r;
                  end
               end
            endcase
            if (phase_ff == 2'd0 && child_l >= cnt_w) phase_in = 2'd2;
            else phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd0 && child_l >= cnt_w) begin
               bst_in = rd_ff;
               best_in = idx_ff;
            end
         end
         dmhs_pkg::ST_DN_SW: begin
            phase_in = 2'd0;
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff);
            if (best_ff != idx_ff) begin
               // child moves up, the sinking entry stays in cur until it settles
               wr_data = bst_ff;
               idx_in = best_ff;
               bst_in = cur_ff;
               best_in = best_ff;
               phase_in = 2'd1;
            end else begin
               wr_data = cur_ff;
               if (rebuild_ff && build_ff != '0) begin
                  idx_in = build_ff - IW'(1);
                  build_in = build_ff - IW'(1);
               end else begin
                  rebuild_in = 1'b1;
                  if (op_ff == dmhs_pkg::OP_PEEK) begin
                     rd_en = 1'b1;
                     rd_addr = '0;
                  end
               end
            end
         end
         dmhs_pkg::ST_SCAN_RD: begin
            rd_en = 1'b1;
            rd_addr = AW'(idx_ff);
         end
         dmhs_pkg::ST_SCAN_CHK: begin
            if (rd_ff.tid == req_ff.tid) begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff);
               wr_data = '{tid: rd_ff.tid, deadline: req_ff.deadline,
                           remaining: req_ff.deadline};
               ok_in = 1'b1;
               rebuild_in = 1'b1;
               phase_in = 2'd0;
               build_in = (cnt_w >> 1);
               idx_in = '0;
               if ((cnt_w >> 1) != '0) begin
                  idx_in = (cnt_w >> 1) - IW'(1);
                  build_in = (cnt_w >> 1) - IW'(1);
               end
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         dmhs_pkg::ST_TICK_RD: begin
            rd_en = 1'b1;
            rd_addr = AW'(idx_ff);
         end
         dmhs_pkg::ST_TICK_WR: begin
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff);
            wr_data = rd_ff;
            if (rd_ff.remaining != {1'b1, {(dmhs_pkg::TIME_W-1){1'b0}}})
               wr_data.remaining = rd_ff.remaining - 32'sd1;
            idx_in = idx_ff + IW'(1);
            if (idx_ff + IW'(1) >= cnt_w) begin
               rebuild_in = 1'b1;
               phase_in = 2'd0;
               idx_in = '0;
               build_in = '0;
               if ((cnt_w >> 1) != '0) begin
                  idx_in = (cnt_w >> 1) - IW'(1);
                  build_in = (cnt_w >> 1) - IW'(1);
               end
            end
         end
         dmhs_pkg::ST_DONE: valid_in = 1'b1;
         default: ;
      endcase
   end

   assign busy              = (state_ff != dmhs_pkg::ST_IDLE);
   assign at_done           = (state_ff == dmhs_pkg::ST_DONE);
   assign rsp_valid         = valid_ff;
   assign rsp_ok            = ok_ff;
   assign rsp_out_tid       = res_ff.tid;
   assign rsp_out_deadline  = res_ff.deadline;
   assign rsp_out_remaining = res_ff.remaining;
   assign rsp_occupancy     = dmhs_pkg::OCC_W'(count_ff);

   `DMHS_ASSERT(a_cnt_cap, clock, reset, count_ff <= CW'(HEAP_CAPACITY), "count over capacity")
   `DMHS_ASSERT(a_valid_idle, clock, reset, rsp_valid |-> !busy, "response while busy")
   `DMHS_ASSERT(a_done_valid, clock, reset, at_done |=> rsp_valid, "done without response")
   `DMHS_ASSERT(a_cnt_stable, clock, reset, (!busy && !start) |=> $stable(count_ff), "count moved while idle")
endmodule
